/* src/vce_pkg.sv */
// ----------------------------------------------------------------------------
// vce_pkg
// Shared types, constants and helpers of the vector clock engine.
// ----------------------------------------------------------------------------
package vce_pkg;

  localparam int NODES        = 8;
  localparam int COUNTER_BITS = 32;
  localparam int NODE_W       = (NODES > 1) ? $clog2(NODES) : 1;

  // Fixed field widths of the streaming items.
  localparam int CMD_W      = 2;
  localparam int IDX_W      = 3;
  localparam int VAL_W      = 32;
  localparam int LOC_W      = 32;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int OWN_W      = 3;
  localparam logic REG_OWN_INDEX = 1'b0;

  typedef logic [COUNTER_BITS-1:0] cnt_t;
  localparam cnt_t CNT_MAX = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADVANCE = 2'd0,
    CMD_MERGE   = 2'd1,
    CMD_COMPARE = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  // One item on its way to the update stage.
  typedef struct packed {
    cmd_t              cmd;
    logic              in_range;
    logic              last;
    logic [NODE_W-1:0] addr;
    cnt_t              val;
  } op_t;

  // Compare accumulators.
  typedef struct packed {
    logic eq;
    logic le;
    logic any_less;
  } acc_t;

  localparam acc_t ACC_RESET = '{eq: 1'b1, le: 1'b1, any_less: 1'b0};

  // What the update stage decides for one item.
  typedef struct packed {
    logic             wr_en;
    cnt_t             wr_data;
    logic [LOC_W-1:0] local_value;
    logic             cmp_valid;
    logic             is_equal;
    logic             is_le;
    logic             is_lt;
    acc_t             acc_nxt;
  } res_t;

  // Incoming values beyond the counter range clamp to the counter maximum.
  function automatic cnt_t sat_value(input logic [VAL_W-1:0] v);
    logic [VAL_W-1:0] hi;
    hi = (COUNTER_BITS >= VAL_W) ? '0 : (v >> COUNTER_BITS);
    if (hi != '0) begin
      return CNT_MAX;
    end
    return cnt_t'(v);
  endfunction

endpackage

/* src/vce_ram.sv */
// ----------------------------------------------------------------------------
// vce_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module vce_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/vce_update.sv */
// ----------------------------------------------------------------------------
// vce_update
// Read-modify-write logic: advance, merge and compare of one counter entry.
// ----------------------------------------------------------------------------
module vce_update (
  input  vce_pkg::op_t  op,
  input  vce_pkg::cnt_t cur,
  input  vce_pkg::acc_t acc,
  output vce_pkg::res_t res
);

  vce_pkg::acc_t acc_upd;

  always_comb begin
    res     = '0;
    acc_upd = acc;
    res.acc_nxt = acc;
    case (op.cmd)
      vce_pkg::CMD_ADVANCE: begin
        if (op.in_range) begin
          res.wr_en       = 1'b1;
          res.wr_data     = (cur == vce_pkg::CNT_MAX) ? cur : cur + 1'b1;
          res.local_value = vce_pkg::LOC_W'(res.wr_data);
        end
      end
      vce_pkg::CMD_MERGE: begin
        if (op.in_range) begin
          res.wr_en       = 1'b1;
          res.wr_data     = (op.val > cur) ? op.val : cur;
          res.local_value = vce_pkg::LOC_W'(res.wr_data);
        end
      end
      vce_pkg::CMD_COMPARE: begin
        if (op.in_range) begin
          if (cur != op.val) acc_upd.eq = 1'b0;
          if (cur > op.val)  acc_upd.le = 1'b0;
          if (cur < op.val)  acc_upd.any_less = 1'b1;
          res.local_value = vce_pkg::LOC_W'(cur);
        end
        if (op.last) begin
          res.cmp_valid = 1'b1;
          res.is_equal  = acc_upd.eq;
          res.is_le     = acc_upd.le;
          res.is_lt     = acc_upd.le & acc_upd.any_less;
          res.acc_nxt   = vce_pkg::ACC_RESET;
        end else begin
          res.acc_nxt = acc_upd;
        end
      end
      default: begin
        res = '0;
        res.acc_nxt = acc;
      end
    endcase
  end

endmodule

/* src/vector_clock_engine.sv */
// ----------------------------------------------------------------------------
// vector_clock_engine
// Vector logical clock with advance, merge and component-wise compare.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on the in_ stream. Each carries a command (advance, merge
//   element or compare element), an entry index, a value and tlast, which
//   closes a compared vector. Every accepted item yields exactly one item on
//   the out_ stream: the touched counter after the step and, on a compare
//   element with tlast, the final equal, less-or-equal and strictly-less
//   flags of the vector compared so far.
//   The own entry index sits in one register at byte address 0 of the APB
//   style port; write it only while no item is in flight.
// Timing:
//   The counters live in a RAM with a registered read. An item reads its
//   entry on the edge that accepts it; it is updated and written back on
//   the edge that advances the update stage, where its result also lands
//   in the output register. A stall on out_tready can hold it in the
//   update stage first. The throughput is one item per cycle while
//   out_tready is high. A write to the entry that the next item reads is forwarded around the RAM.
// Reset and stalls:
//   Reset clears the per-entry valid bits, so every counter reads as zero
//   at once, sets own_index to 0 and restores the compare accumulators.
//   While out_tready is low the result waits in the output register, one
//   more item waits in the update stage, and in_tready then drops.
// ----------------------------------------------------------------------------
module vector_clock_engine (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input items.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [1:0] command, [4:2] elem_index, [36:5] elem_value, [39:37] zero
  input  logic [vce_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                              in_tlast,
  // Result items.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [31:0] local_value, [32] cmp_valid, [33] is_equal, [34] is_le,
  // [35] is_lt, [39:36] zero
  output logic [vce_pkg::OUT_DATA_W-1:0]    out_tdata,
  // Configuration port.
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [vce_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [vce_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [vce_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);

  // Configuration register.
  logic [vce_pkg::OWN_W-1:0] own_index_r;
  logic                      cfg_sel_own;

  // Update stage.
  logic                  s2_valid_r;
  vce_pkg::op_t          s2_op_r;
  logic                  fwd_hit_r;
  vce_pkg::cnt_t         fwd_data_r;
  logic                  ent_vld_r;
  vce_pkg::acc_t         acc_r;
  logic [vce_pkg::NODES-1:0] vld_r;

  // Output register.
  logic                           out_valid_r;
  logic [vce_pkg::OUT_DATA_W-1:0] out_data_r;

  logic          in_accept;
  logic          s2_adv;
  logic          wr_fire;
  vce_pkg::op_t  op_nxt;
  vce_pkg::cmd_t in_cmd;
  logic [vce_pkg::IDX_W-1:0] in_idx;
  vce_pkg::cnt_t ram_q;
  vce_pkg::cnt_t cur;
  vce_pkg::res_t res;

  assign cfg_pready  = 1'b1;
  assign cfg_sel_own = (cfg_paddr[vce_pkg::CFG_ADDR_W-1] == vce_pkg::REG_OWN_INDEX);
  assign cfg_prdata  = cfg_sel_own ? vce_pkg::CFG_DATA_W'(own_index_r) : '0;

  // The update stage moves on whenever the output register is free or drains.
  assign s2_adv    = s2_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s2_valid_r || s2_adv;
  assign in_accept = in_tvalid && in_tready;
  assign wr_fire   = s2_adv && res.wr_en;

  assign in_cmd = vce_pkg::cmd_t'(in_tdata[1:0]);
  assign in_idx = in_tdata[4:2];

  // An advance touches the own entry; all other commands the carried index.
  always_comb begin
    op_nxt      = '0;
    op_nxt.cmd  = in_cmd;
    op_nxt.last = in_tlast;
    op_nxt.val  = vce_pkg::sat_value(in_tdata[36:5]);
    if (in_cmd == vce_pkg::CMD_ADVANCE) begin
      op_nxt.addr     = (vce_pkg::NODE_W)'(own_index_r);
      op_nxt.in_range = int'(own_index_r) < vce_pkg::NODES;
    end else begin
      op_nxt.addr     = (vce_pkg::NODE_W)'(in_idx);
      op_nxt.in_range = int'(in_idx) < vce_pkg::NODES;
    end
  end

  vce_ram #(
    .WIDTH (vce_pkg::COUNTER_BITS),
    .DEPTH (vce_pkg::NODES)
  ) u_ram (
    .clk   (clk),
    .we    (wr_fire),
    .waddr (s2_op_r.addr),
    .wdata (res.wr_data),
    .re    (in_accept),
    .raddr (op_nxt.addr),
    .rdata (ram_q)
  );

  // Entries never written since reset read as zero; a write on the accept
  // edge of the same entry is taken from the forwarding register.
  assign cur = fwd_hit_r ? fwd_data_r : (ent_vld_r ? ram_q : '0);

  vce_update u_update (
    .op  (s2_op_r),
    .cur (cur),
    .acc (acc_r),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_index_r <= '0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= vce_pkg::ACC_RESET;
      vld_r       <= '0;
      fwd_hit_r   <= 1'b0;
      ent_vld_r   <= 1'b0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_sel_own) begin
        own_index_r <= cfg_pwdata[vce_pkg::OWN_W-1:0];
      end

      if (in_accept) begin
        s2_valid_r <= 1'b1;
        fwd_hit_r  <= wr_fire && (s2_op_r.addr == op_nxt.addr);
        ent_vld_r  <= vld_r[op_nxt.addr];
      end else if (s2_adv) begin
        s2_valid_r <= 1'b0;
      end

      if (wr_fire) begin
        vld_r[s2_op_r.addr] <= 1'b1;
      end

      if (s2_adv) begin
        acc_r       <= res.acc_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s2_op_r    <= op_nxt;
      fwd_data_r <= res.wr_data;
    end
    if (s2_adv) begin
      out_data_r <= {4'b0000, res.is_lt, res.is_le, res.is_equal, res.cmp_valid,
                     res.local_value};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* src/vce_checker.sv */
// ----------------------------------------------------------------------------
// vce_checker
// Port-level checks of the vector clock engine's result stream.
// ----------------------------------------------------------------------------
module vce_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [vce_pkg::OUT_DATA_W-1:0] out_tdata
);

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Flags are only reported on a final compare element.
  a_flags_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[32] |-> out_tdata[35:33] == 3'b000)
    else $error("compare flags set without cmp_valid");

  // Strictly less implies less-or-equal and not equal.
  a_lt_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[35] |-> out_tdata[34] && !out_tdata[33])
    else $error("is_lt inconsistent with is_le or is_equal");

  // Equal vectors are also less-or-equal.
  a_eq_le: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[33] |-> out_tdata[34])
    else $error("is_equal without is_le");

  // Padding bits stay zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39:36] == 4'b0000)
    else $error("nonzero padding in result");

endmodule

bind vector_clock_engine vce_checker u_vce_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
